[rtl/core/mext_pkg.sv]
package mext_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DtW   = 31;
  localparam int unsigned RowW  = 2;
  localparam int unsigned ProdW = 64;
  localparam logic [RowW-1:0] LastRow = 2'd2;

  typedef logic signed [DataW-1:0] val_t;
  typedef val_t [2:0][2:0] mat_t;
  typedef val_t [2:0] row_t;

  // clamp a wide signed value to the 32-bit range
  function automatic val_t sat32(input logic signed [ProdW+1:0] v);
    logic signed [ProdW+1:0] hi;
    logic signed [ProdW+1:0] lo;
    hi = (ProdW+2)'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = -hi - (ProdW+2)'(1);
    if (v > hi) begin
      return val_t'(hi[DataW-1:0]);
    end else if (v < lo) begin
      return val_t'(lo[DataW-1:0]);
    end
    return val_t'(v[DataW-1:0]);
  endfunction

endpackage

[rtl/core/mext_if.sv]
interface mext_in_if;
  logic valid;
  logic ready;
  mext_pkg::mat_t a;
  logic [mext_pkg::DtW-1:0] time_step;
  modport source (output valid, a, time_step, input ready);
  modport sink (input valid, a, time_step, output ready);
endinterface

interface mext_out_if;
  logic valid;
  logic ready;
  logic [mext_pkg::RowW-1:0] row_index;
  mext_pkg::row_t second_c;
  mext_pkg::row_t third_c;
  logic last_row;
  modport source (output valid, row_index, second_c, third_c, last_row, input ready);
  modport sink (input valid, row_index, second_c, third_c, last_row, output ready);
endinterface

[rtl/core/mext_lane.sv]
// one lane: dot product of a row with a column, floored products, saturated sum
module mext_lane #(
  parameter int unsigned FracBits = 24
) (
  input  mext_pkg::row_t x_i,
  input  mext_pkg::row_t y_i,
  output mext_pkg::val_t r_o
);
  logic signed [mext_pkg::ProdW-1:0] prod [3];
  logic signed [mext_pkg::ProdW+1:0] acc;

  always_comb begin
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      prod[k] = mext_pkg::ProdW'(x_i[k]) * mext_pkg::ProdW'(y_i[k]);
      acc = acc + (mext_pkg::ProdW+2)'(prod[k] >>> FracBits);
    end
    r_o = mext_pkg::sat32(acc);
  end
endmodule

[rtl/core/mext_merge.sv]
// combines one row of M, P2, P3 into both series sums
module mext_merge #(
  parameter int unsigned FracBits = 24
) (
  input  logic [mext_pkg::RowW-1:0] row_i,
  input  mext_pkg::row_t m_i,
  input  mext_pkg::row_t p2_i,
  input  mext_pkg::row_t p3_i,
  output mext_pkg::row_t e2_o,
  output mext_pkg::row_t e3_o
);
  // ceil(2^34 / 3), exact for biased values below 2^33
  localparam logic [32:0] RecipThird = 33'd5726623062;
  // 3 * 2^30 makes every halved value non-negative and keeps it a multiple-of-three shift
  localparam logic [31:0] DivBias = 32'hC0000000;
  localparam logic signed [35:0] DivOffset = 36'sd1073741824;
  logic signed [35:0] base [3];
  logic signed [30:0] half3 [3];
  logic [31:0] biased [3];
  logic [64:0] prod3 [3];
  logic signed [35:0] sixth [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      base[j] = 36'(m_i[j]) + 36'(p2_i[j] >>> 1);
      if (row_i == 2'(j)) base[j] = base[j] + (36'sd1 <<< FracBits);
      // floor divide by six: floor halve, bias positive, reciprocal of three
      half3[j] = p3_i[j][31:1];
      biased[j] = 32'(half3[j]) + DivBias;
      prod3[j] = 65'(biased[j]) * 65'(RecipThird);
      sixth[j] = 36'(signed'({1'b0, prod3[j][64:34]})) - DivOffset;
      e2_o[j] = mext_pkg::sat32(66'(base[j]));
      e3_o[j] = mext_pkg::sat32(66'(base[j] + sixth[j]));
    end
  end
endmodule

[rtl/core/matrix_exponential_taylor_3x3_unit.sv]
// rows of a matrix follow one per cycle while the receiver is ready
// the three-row output sequencer holds each matrix in stage 3 until its last row leaves
// pipeline: scale stage, square stage, cube stage, then row output register
// reset: rst_ni asynchronous active low clears all valid bits and the row counter;
//   datapath registers are not reset
module matrix_exponential_taylor_3x3_unit #(
  parameter int unsigned FRAC_BITS = 24
) (
  input logic clk_i,
  input logic rst_ni,
  mext_in_if.sink   in_i,
  mext_out_if.source out_o
);
  mext_pkg::mat_t m_d, p2_d, p3_d;
  mext_pkg::mat_t m1_q, m2_q, p2_q, m3_q, p2b_q, p3_q;
  logic v1_q, v2_q, v3_q;
  logic [mext_pkg::RowW-1:0] row_q;
  logic out_v_q;
  logic adv3;
  mext_pkg::row_t e2, e3;

  // stage 3 holds a matrix until its three rows have left
  logic out_free, last_go;
  assign out_free = !out_v_q || out_o.ready;
  assign last_go  = v3_q && out_free && row_q == mext_pkg::LastRow;
  assign adv3     = !v3_q || last_go;
  // stage 1/2 stall only when downstream is full
  logic adv2, adv1;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_i.ready = adv1;

  // scale lanes: M = sat(floor(dt*a))
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [mext_pkg::ProdW-1:0] p;
        p = mext_pkg::ProdW'(signed'({1'b0, in_i.time_step})) *
            mext_pkg::ProdW'(in_i.a[i][j]);
        m_d[i][j] = mext_pkg::sat32((mext_pkg::ProdW+2)'(p >>> FRAC_BITS));
      end
    end
  end

  // nine lanes per matrix product
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mext_pkg::row_t col_a, col_b;
      assign col_a = '{m1_q[2][j], m1_q[1][j], m1_q[0][j]};
      assign col_b = '{m2_q[2][j], m2_q[1][j], m2_q[0][j]};
      mext_lane #(.FracBits(FRAC_BITS)) u_sq (
        .x_i(m1_q[i]), .y_i(col_a), .r_o(p2_d[i][j]));
      mext_lane #(.FracBits(FRAC_BITS)) u_cu (
        .x_i(p2_q[i]), .y_i(col_b), .r_o(p3_d[i][j]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      row_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (out_free) out_v_q <= v3_q;
      if (v3_q && out_free) begin
        row_q <= (row_q == mext_pkg::LastRow) ? '0 : row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) m1_q <= m_d;
    if (adv2) begin
      m2_q <= m1_q;
      p2_q <= p2_d;
    end
    if (adv3) begin
      m3_q <= m2_q;
      p2b_q <= p2_q;
      p3_q <= p3_d;
    end
    if (v3_q && out_free) begin
      out_o.row_index <= row_q;
      out_o.second_c <= e2;
      out_o.third_c <= e3;
      out_o.last_row <= row_q == mext_pkg::LastRow;
    end
  end

  // merging stage picks the current row of each stored term
  mext_merge #(.FracBits(FRAC_BITS)) u_merge (
    .row_i(row_q), .m_i(m3_q[row_q]), .p2_i(p2b_q[row_q]), .p3_i(p3_q[row_q]),
    .e2_o(e2), .e3_o(e3));

  assign out_o.valid = out_v_q;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != 2'd3) else $error("row counter out of range");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_o.last_row == (out_o.row_index == mext_pkg::LastRow)))
    else $error("last flag mismatch");
  a_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> row_q == '0) else $error("row counter not parked");
endmodule

[tb/tb_matrix_exponential_taylor_3x3_unit.sv]
`timescale 1ns / 100ps

module tb_matrix_exponential_taylor_3x3_unit;

  localparam int unsigned Frac = 24;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [mext_pkg::RowW-1:0] row_index;
    mext_pkg::row_t second_c;
    mext_pkg::row_t third_c;
    logic last_row;
  } row_beat_t;

  // clamp to the signed 32-bit range
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // fixed-point product with floor rounding; an arithmetic shift is a floor
  function automatic longint fx_mul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> Frac;
  endfunction

  function automatic longint floor_by(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) < 0) q = q - 1;
    return q;
  endfunction

  // scoreboard of expected row beats
  class exp_taylor_board;
    row_beat_t pending_rows[$];
    int mismatches;
    int rows_checked;

    function void note_matrix(mext_pkg::mat_t a, logic [mext_pkg::DtW-1:0] dt);
      longint m[3][3], p2[3][3], p3[3][3];
      longint acc, base, one;
      row_beat_t rb;
      one = longint'(1) << Frac;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = clamp32(fx_mul(longint'({1'b0, dt}), longint'(a[i][j])));
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += fx_mul(m[i][k], m[k][j]);
          p2[i][j] = clamp32(acc);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += fx_mul(p2[i][k], m[k][j]);
          p3[i][j] = clamp32(acc);
        end
      for (int i = 0; i < 3; i++) begin
        rb.row_index = i[mext_pkg::RowW-1:0];
        rb.last_row = (i == 2);
        for (int j = 0; j < 3; j++) begin
          base = m[i][j] + floor_by(p2[i][j], 2);
          if (i == j) base += one;
          rb.second_c[j] = mext_pkg::val_t'(clamp32(base));
          rb.third_c[j] = mext_pkg::val_t'(clamp32(base + floor_by(p3[i][j], 6)));
        end
        pending_rows.push_back(rb);
      end
    endfunction

    task check_row(row_beat_t got);
      row_beat_t want;
      rows_checked++;
      if (pending_rows.size() == 0) begin
        report_err("row beat with nothing pending", 0, 0);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index)
        report_err("row_index", got.row_index, want.row_index);
      if (got.last_row !== want.last_row)
        report_err("last_row", got.last_row, want.last_row);
      for (int j = 0; j < 3; j++) begin
        if (got.second_c[j] !== want.second_c[j])
          report_err("second_c", got.second_c[j], want.second_c[j]);
        if (got.third_c[j] !== want.third_c[j])
          report_err("third_c", got.third_c[j], want.third_c[j]);
      end
    endtask

    task report_err(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch %0s: got %0d expected %0d (row beat %0d)",
                 what, got, want, rows_checked);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  mext_in_if in_if ();
  mext_out_if out_if ();

  matrix_exponential_taylor_3x3_unit #(.FRAC_BITS(Frac)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  exp_taylor_board board = new();

  // idle percentages for sender and receiver, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down in the ready process
  int hold_cycles = 0;
  int matrices_sent = 0;
  longint cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // input beats are noted at the edge where they are accepted
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      board.note_matrix(in_if.a, in_if.time_step);
    end
  end

  // output beats are checked at the edge where they are accepted
  always @(posedge clk_i) begin
    row_beat_t rb;
    if (rst_ni && out_if.valid && out_if.ready) begin
      rb.row_index = out_if.row_index;
      rb.second_c = out_if.second_c;
      rb.third_c = out_if.third_c;
      rb.last_row = out_if.last_row;
      board.check_row(rb);
    end
  end

  // receiver: ready changes on the falling edge only
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // pick an element value: extremes, small values within plus or minus two, or anything
  function automatic mext_pkg::val_t pick_elem();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4, 5: return mext_pkg::val_t'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
      default: return mext_pkg::val_t'($urandom);
    endcase
  endfunction

  function automatic logic [mext_pkg::DtW-1:0] pick_dt();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2, 3, 4: return mext_pkg::DtW'($urandom_range(0, 2 ** 22));
      5: return mext_pkg::DtW'(1 << Frac);
      default: return mext_pkg::DtW'($urandom);
    endcase
  endfunction

  // offer one matrix beat and hold it until accepted; valid stays up for the next beat
  task automatic send_matrix(mext_pkg::mat_t a, logic [mext_pkg::DtW-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.a <= a;
    in_if.time_step <= dt;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    matrices_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fill(mext_pkg::val_t v, logic [mext_pkg::DtW-1:0] dt);
    mext_pkg::mat_t a;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = v;
    send_matrix(a, dt);
  endtask

  task automatic send_random(int count);
    mext_pkg::mat_t a;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) a[i][j] = pick_elem();
      send_matrix(a, pick_dt());
    end
  endtask

  initial begin
    mext_pkg::mat_t a;
    int drain;
    in_if.valid = 1'b0;
    in_if.a = '0;
    in_if.time_step = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero matrix, dt zero, identity-ish, extremes, saturation
    send_fill(32'sd0, mext_pkg::DtW'(1 << Frac));
    send_fill(32'sh7fffffff, '0);
    send_fill(32'sh7fffffff, '1);
    send_fill(32'sh80000000, '1);
    send_fill(32'sh80000000, mext_pkg::DtW'(1 << Frac));
    send_fill(32'sh7fffffff, mext_pkg::DtW'(1 << Frac));
    send_fill(-32'sd1, mext_pkg::DtW'(1));
    send_fill(-32'sd1, '1);
    send_fill(32'sd1, '1);
    send_fill(32'sh01000000, mext_pkg::DtW'(1 << Frac));
    send_fill(-32'sh01000000, mext_pkg::DtW'(1 << Frac));
    send_fill(32'sh08000000, mext_pkg::DtW'(1 << Frac));
    send_fill(-32'sh08000000, mext_pkg::DtW'(1 << Frac));
    send_fill(32'sh55555555, mext_pkg::DtW'(31'h2aaaaaaa));
    send_fill(32'shaaaaaaaa, mext_pkg::DtW'(31'h55555555));
    // diagonal matrix with mixed signs, off-diagonal zero
    a = '0;
    a[0][0] = 32'sh01000000;
    a[1][1] = -32'sh02000000;
    a[2][2] = 32'sh00800000;
    send_matrix(a, mext_pkg::DtW'(1 << Frac));
    // rotation generator, skew-symmetric
    a = '0;
    a[0][1] = -32'sh00400000;
    a[1][0] = 32'sh00400000;
    send_matrix(a, mext_pkg::DtW'(1 << (Frac - 2)));

    // random phases with different idling patterns
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(80);
    send_idle_pct = 58; recv_stall_pct = 0;  send_random(70);
    send_idle_pct = 0;  recv_stall_pct = 58; send_random(70);
    send_idle_pct = 6;  recv_stall_pct = 6;  send_random(70);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;  recv_stall_pct = 0;
    hold_cycles = 200;
    send_random(45);
    in_if.valid <= 1'b0;

    drain = 0;
    while (board.pending_rows.size() != 0) @(posedge clk_i);
    while (drain < 20) begin
      @(posedge clk_i);
      drain++;
    end

    $display("sent %0d matrices, checked %0d row beats", matrices_sent, board.rows_checked);
    $display("covered extremes, idle sender, stalling receiver and a long hold-off");
    if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
